// ===== design/tla_pkg.sv =====
`default_nettype none
package tla_pkg;

    // Default sizes of the line store and the terminator.
    localparam int LINE_DEPTH_DEF = 64;
    localparam int END_MAX_DEF    = 8;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_LENGTH     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_BYTES      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECEIVE_ENABLE = 8'd3;

    // Register reset values; the terminator defaults to CR LF.
    localparam logic [6:0]  LINE_LIMIT_RST = 7'd64;
    localparam logic [3:0]  END_LENGTH_DEF = 4'd2;
    localparam logic [63:0] END_BYTES_DEF  = 64'h0000_0000_0000_0A0D;

    // Line end reasons.
    localparam logic REASON_TERM = 1'b0;
    localparam logic REASON_FULL = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;
        logic start_drain;
        logic reason;
        logic next;
        logic clear;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic enabled;
        logic full;
        logic fill_zero;
        logic match;
        logic last;
    } t_status;

endpackage
`default_nettype wire

// ===== design/tla_datapath.sv =====
`default_nettype none
module tla_datapath #(
    parameter int LINE_DEPTH = tla_pkg::LINE_DEPTH_DEF,
    parameter int END_MAX    = tla_pkg::END_MAX_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    input  wire logic [tla_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tla_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [7:0]                     i_rx_byte,
    input  wire tla_pkg::t_cmd                  i_cmd,
    output tla_pkg::t_status                    o_status,
    output logic [7:0]                          o_line_byte,
    output logic                                o_end_reason,
    output logic [5:0]                          o_line_length
);

    localparam int FILL_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    // Configuration registers.
    logic [6:0]  r_line_limit;
    logic [3:0]  r_end_length;
    logic [63:0] r_end_bytes;
    logic        r_rx_en;

    // Line state.
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_rd_addr;
    logic              r_reason;
    logic [7:0]        r_rd_data;
    logic [7:0]        r_store [LINE_DEPTH];
    logic [7:0]        r_tail  [END_MAX];

    logic [6:0] w_limit;
    logic [3:0] w_len;
    logic [3:0] w_idx;
    logic       w_match;

    // Effective limit and terminator length, clamped to the built sizes.
    assign w_limit = (r_line_limit > 7'(LINE_DEPTH)) ? 7'(LINE_DEPTH) : r_line_limit;
    assign w_len   = (r_end_length > 4'(END_MAX)) ? 4'(END_MAX) : r_end_length;

    // Compare the newest stored bytes against the terminator, newest byte last.
    always_comb begin
        w_match = (7'(r_fill) >= 7'(w_len));
        w_idx   = 4'd0;
        for (int j = 0; j < END_MAX; j++) begin
            if (4'(j) < w_len) begin
                w_idx = w_len - 4'd1 - 4'(j);
                if (r_tail[j] != r_end_bytes[{w_idx[2:0], 3'b000} +: 8]) begin
                    w_match = 1'b0;
                end
            end
        end
    end

    // Status toward the controller.
    always_comb begin
        o_status.enabled   = r_rx_en && (r_line_limit != 7'd0);
        o_status.full      = 7'(r_fill) >= (w_limit - 7'd1);
        o_status.fill_zero = (r_fill == '0);
        o_status.match     = w_match;
        o_status.last      = (r_rd_addr == (r_fill - FILL_W'(1)));
    end

    // Configuration writes and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_limit <= tla_pkg::LINE_LIMIT_RST;
            r_end_length <= tla_pkg::END_LENGTH_DEF;
            r_end_bytes  <= tla_pkg::END_BYTES_DEF;
            r_rx_en      <= 1'b0;
            r_fill       <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tla_pkg::REG_LINE_LIMIT:     r_line_limit <= i_cfg_data[6:0];
                    tla_pkg::REG_END_LENGTH:     r_end_length <= i_cfg_data[3:0];
                    tla_pkg::REG_END_BYTES:      r_end_bytes  <= i_cfg_data;
                    tla_pkg::REG_RECEIVE_ENABLE: r_rx_en      <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.store) begin
                r_fill <= r_fill + FILL_W'(1);
                // A zero terminator length falls back to CR LF for good.
                if (r_end_length == 4'd0) begin
                    r_end_length <= tla_pkg::END_LENGTH_DEF;
                    r_end_bytes  <= tla_pkg::END_BYTES_DEF;
                end
            end
            if (i_cmd.clear) begin
                r_fill <= '0;
            end
        end
    end

    // Drain pointer and end reason; payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_drain) begin
            r_rd_addr <= '0;
            r_reason  <= i_cmd.reason;
        end else if (i_cmd.next) begin
            r_rd_addr <= r_rd_addr + FILL_W'(1);
        end
    end

    // Line store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_store[r_fill] <= i_rx_byte;
        end
        r_rd_data <= r_store[r_rd_addr];
    end

    // History of the most recently stored bytes, newest at entry zero.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_tail[0] <= i_rx_byte;
            for (int i = 1; i < END_MAX; i++) begin
                r_tail[i] <= r_tail[i-1];
            end
        end
    end

    assign o_line_byte   = r_rd_data;
    assign o_end_reason  = r_reason;
    assign o_line_length = 6'(r_fill);

endmodule
`default_nettype wire

// ===== design/tla_ctrl.sv =====
`default_nettype none
module tla_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_out_ready,
    input  wire tla_pkg::t_status i_status,
    output tla_pkg::t_cmd         o_cmd,
    output logic                  o_in_ready,
    output logic                  o_out_valid
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_SHOW
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   n_in_ready;
    logic   r_out_valid;
    logic   n_out_valid;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_status.enabled) begin
                    if (i_status.full) begin
                        // Store full: the byte is dropped and a non-empty line flushed.
                        if (!i_status.fill_zero) begin
                            o_cmd.start_drain = 1'b1;
                            o_cmd.reason      = tla_pkg::REASON_FULL;
                            n_state           = ST_READ;
                        end
                    end else begin
                        o_cmd.store = 1'b1;
                        n_state     = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (i_status.match) begin
                    o_cmd.start_drain = 1'b1;
                    o_cmd.reason      = tla_pkg::REASON_TERM;
                    n_state           = ST_READ;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                n_state = ST_SHOW;
            end
            ST_SHOW: begin
                if (i_out_ready) begin
                    if (i_status.last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        o_cmd.next = 1'b1;
                        n_state    = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_in_ready  = (n_state == ST_IDLE);
        n_out_valid = (n_state == ST_SHOW);
    end

    // State and registered handshake outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= n_in_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== design/terminated_line_assembler.sv =====
`default_nettype none
// Line assembler for received serial bytes. Each accepted byte is appended to a
// line store of LINE_DEPTH bytes; a line is emitted once its last stored bytes
// equal the configured terminator (CR LF after reset), or flushed as overflow
// when a byte arrives at a full store (that byte is dropped). A stored byte
// goes through acceptance and then the terminator compare; an ignored or
// dropped byte goes through acceptance alone. While a line is emitted, each
// byte is fetched through the registered read port of the line store before
// it is presented, and the block also waits out any output stall. No new byte
// is accepted until the whole line has been delivered. Configuration writes
// are always accepted and must be issued only while the block is idle.
module terminated_line_assembler #(
    parameter int LINE_DEPTH = tla_pkg::LINE_DEPTH_DEF,
    parameter int END_MAX    = tla_pkg::END_MAX_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [tla_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tla_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [7:0]                     i_rx_byte,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [7:0]                          o_line_byte,
    output logic                                o_last,
    output logic                                o_end_reason,
    output logic [5:0]                          o_line_length
);

    tla_pkg::t_cmd    w_cmd;
    tla_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;
    assign o_last      = w_status.last;

    tla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    tla_datapath #(
        .LINE_DEPTH (LINE_DEPTH),
        .END_MAX    (END_MAX)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_rx_byte     (i_rx_byte),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_line_byte   (o_line_byte),
        .o_end_reason  (o_end_reason),
        .o_line_length (o_line_length)
    );

    // Input and output sides are never open at the same time.
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while a line byte is presented");

    // After the final byte of a line goes out, the block is ready for input.
    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> o_in_ready)
        else $error("block not idle after the last byte of a line");

    // An emitted line is never empty.
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_line_length != 6'd0))
        else $error("line byte presented with zero line length");

endmodule
`default_nettype wire

// ===== test/terminated_line_assembler_tb.sv =====
`timescale 1ns / 100ps
module terminated_line_assembler_tb;

    // Cycles without any transaction before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 3000;
    // Cycles allowed for a byte still in the compare stage after the last line byte.
    localparam int SETTLE_CYC     = 6;
    // Cycles of quiet at the end of the run.
    localparam int TAIL_CYC       = 20;
    // Length of the long receiver hold-off.
    localparam int HOLD_CYC       = 400;

    // One byte of an emitted line as it appears on the output channel.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       reason;
        logic [5:0] len;
    } t_line_beat;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [tla_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [tla_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    logic [7:0]                     i_rx_byte = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    logic [7:0]                     o_line_byte;
    logic                           o_last;
    logic                           o_end_reason;
    logic [5:0]                     o_line_length;

    // Shadow copy of the registers and the line store.
    logic [6:0]  lim_r;
    logic [3:0]  elen_r;
    logic [63:0] ebytes_r;
    logic        rx_en_r;
    logic [7:0]  line_mem [tla_pkg::LINE_DEPTH_DEF];
    int          fill;

    // Line bytes that are still due on the output.
    t_line_beat  line_q [$];
    t_line_beat  due_beat;

    int err_cnt = 0;
    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int hold_left = 0;
    int quiet_cyc = 0;

    terminated_line_assembler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_line_byte   (o_line_byte),
        .o_last        (o_last),
        .o_end_reason  (o_end_reason),
        .o_line_length (o_line_length)
    );

    always #5 i_clk = ~i_clk;

    // Register state after reset.
    function void shadow_reset();
        lim_r    = tla_pkg::LINE_LIMIT_RST;
        elen_r   = tla_pkg::END_LENGTH_DEF;
        ebytes_r = tla_pkg::END_BYTES_DEF;
        rx_en_r  = 1'b0;
        fill     = 0;
    endfunction

    function void shadow_write(logic [tla_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
        case (idx)
            tla_pkg::REG_LINE_LIMIT:     lim_r    = data[6:0];
            tla_pkg::REG_END_LENGTH:     elen_r   = data[3:0];
            tla_pkg::REG_END_BYTES:      ebytes_r = data;
            tla_pkg::REG_RECEIVE_ENABLE: rx_en_r  = data[0];
            default: ;
        endcase
    endfunction

    // Queue every stored byte as one output beat and empty the store.
    function void flush_line(logic reason);
        t_line_beat beat;
        int n;
        n = fill;
        for (int k = 0; k < n; k++) begin
            beat.data   = line_mem[k];
            beat.last   = (k + 1 == n);
            beat.reason = reason;
            beat.len    = n[5:0];
            line_q.push_back(beat);
        end
        fill = 0;
    endfunction

    // True when the newest stored bytes equal the terminator.
    function bit terminator_seen();
        int len;
        len = (elen_r > tla_pkg::END_MAX_DEF) ? tla_pkg::END_MAX_DEF : elen_r;
        if (fill < len)
            return 1'b0;
        for (int j = 1; j <= len; j++) begin
            if (line_mem[fill - j] != ebytes_r[8 * (len - j) +: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Work out the line bytes that one accepted received byte releases.
    function void predict_rx(logic [7:0] b);
        int lim;
        if (!rx_en_r)
            return;
        lim = lim_r;
        if (lim == 0)
            return;
        if (lim > tla_pkg::LINE_DEPTH_DEF)
            lim = tla_pkg::LINE_DEPTH_DEF;
        if (fill >= lim - 1) begin
            flush_line(tla_pkg::REASON_FULL);
            return;
        end
        line_mem[fill] = b;
        fill++;
        if (elen_r == 0) begin
            elen_r   = tla_pkg::END_LENGTH_DEF;
            ebytes_r = tla_pkg::END_BYTES_DEF;
        end
        if (terminator_seen())
            flush_line(tla_pkg::REASON_TERM);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            err_cnt++;
        end
    endfunction

    // Output side: compare each line byte with the oldest one due, then pick the next ready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (line_q.size() == 0) begin
                $display("%0t: unexpected line byte, expected none, actual 0x%0h",
                         $time, o_line_byte);
                err_cnt++;
            end else begin
                due_beat = line_q.pop_front();
                check_field("line_byte", due_beat.data, o_line_byte);
                check_field("last", 8'(due_beat.last), 8'(o_last));
                check_field("end_reason", 8'(due_beat.reason), 8'(o_end_reason));
                check_field("line_length", 8'(due_beat.len), 8'(o_line_length));
            end
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cyc <= 0;
        else
            quiet_cyc <= quiet_cyc + 1;
        if (quiet_cyc >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cyc);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one received byte, after a random gap, and wait until it is taken.
    task automatic send_rx(input logic [7:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < in_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        predict_rx(b);
    endtask

    // Write one register; valid stays up until cfg_release.
    task automatic write_reg(input logic [tla_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_write(idx, data);
    endtask

    task automatic cfg_release();
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (line_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Bring the block to rest so that registers may be written.
    task automatic quiesce();
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [6:0] lim, input logic [3:0] elen,
                                input logic [63:0] eb, input logic en);
        quiesce();
        write_reg(tla_pkg::REG_LINE_LIMIT, {57'd0, lim});
        write_reg(tla_pkg::REG_END_LENGTH, {60'd0, elen});
        write_reg(tla_pkg::REG_END_BYTES, eb);
        write_reg(tla_pkg::REG_RECEIVE_ENABLE, {63'd0, en});
        cfg_release();
    endtask

    // Bytes arriving while reception is off are ignored.
    task automatic test_rx_disabled();
        send_rx(8'h00);
        send_rx(8'hFF);
    endtask

    // A short line closed by the default CR LF terminator.
    task automatic test_crlf_line();
        quiesce();
        write_reg(tla_pkg::REG_RECEIVE_ENABLE, 64'd1);
        cfg_release();
        send_rx(8'hFF);
        send_rx(8'h00);
        send_rx(8'h0D);
        send_rx(8'h0A);
    endtask

    // Line limits of two (one byte stored), one (nothing stored) and zero (reception off).
    task automatic test_limit_edges();
        quiesce();
        write_reg(tla_pkg::REG_LINE_LIMIT, 64'd2);
        cfg_release();
        send_rx(8'h55);
        send_rx(8'hAA);
        quiesce();
        write_reg(tla_pkg::REG_LINE_LIMIT, 64'd1);
        cfg_release();
        send_rx(8'h11);
        quiesce();
        write_reg(tla_pkg::REG_LINE_LIMIT, 64'd0);
        cfg_release();
        send_rx(8'h22);
    endtask

    // Oversized limit and terminator length; the tail of the terminator alone is too short.
    task automatic test_long_terminator();
        quiesce();
        write_reg(tla_pkg::REG_LINE_LIMIT, 64'd100);
        write_reg(tla_pkg::REG_END_LENGTH, 64'd12);
        write_reg(tla_pkg::REG_END_BYTES, 64'h8877_6655_4433_2211);
        cfg_release();
        send_rx(8'h77);
        send_rx(8'h88);
        for (int k = 0; k < 8; k++)
            send_rx(8'(8'h11 * (k + 1)));
    endtask

    // A zero terminator length falls back to CR LF on the next stored byte.
    task automatic test_zero_terminator_length();
        quiesce();
        write_reg(tla_pkg::REG_END_LENGTH, 64'd0);
        cfg_release();
        send_rx(8'h58);
        send_rx(8'h0D);
        send_rx(8'h0A);
    endtask

    // Lowering the limit below the fill flushes the whole stored line.
    task automatic test_limit_lowered();
        quiesce();
        write_reg(tla_pkg::REG_LINE_LIMIT, 64'd64);
        cfg_release();
        send_rx(8'h61);
        send_rx(8'h62);
        send_rx(8'h63);
        send_rx(8'h64);
        quiesce();
        write_reg(tla_pkg::REG_LINE_LIMIT, 64'd3);
        cfg_release();
        send_rx(8'h65);
    endtask

    // Long receiver hold-off while lines keep coming, then a pause until all is out.
    task automatic test_backpressure();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        program_regs(7'd64, tla_pkg::END_LENGTH_DEF, tla_pkg::END_BYTES_DEF, 1'b1);
        hold_left = HOLD_CYC;
        for (int n = 0; n < 3; n++) begin
            for (int k = 0; k < 8; k++)
                send_rx(8'($urandom_range(255)));
            send_rx(8'h0D);
            send_rx(8'h0A);
        end
        quiesce();
        for (int k = 0; k < 5; k++)
            send_rx(8'($urandom_range(255)));
        send_rx(8'h0D);
        send_rx(8'h0A);
        quiesce();
    endtask

    // Mostly terminated lines with random content, plus noise and overlong lines.
    task automatic random_traffic(input int nitems);
        int sent, lim, elen, maxc, len, kind;
        sent = 0;
        lim  = (lim_r > tla_pkg::LINE_DEPTH_DEF) ? tla_pkg::LINE_DEPTH_DEF : lim_r;
        elen = (elen_r > tla_pkg::END_MAX_DEF) ? tla_pkg::END_MAX_DEF : elen_r;
        maxc = lim - 1 - elen;
        while (sent < nitems) begin
            kind = $urandom_range(99);
            if (kind < 70 && maxc >= 0) begin
                if ($urandom_range(7) == 0)
                    len = $urandom_range(maxc);
                else
                    len = $urandom_range((maxc < 6) ? maxc : 6);
                for (int k = 0; k < len; k++)
                    send_rx(8'($urandom_range(255)));
                for (int k = 0; k < elen; k++)
                    send_rx(ebytes_r[8 * k +: 8]);
                sent += len + elen;
            end else if (kind < 88) begin
                len = $urandom_range(4, 1);
                for (int k = 0; k < len; k++)
                    send_rx(8'($urandom_range(255)));
                sent += len;
            end else begin
                for (int k = 0; k < lim; k++)
                    send_rx(8'($urandom_range(255)));
                sent += lim;
            end
        end
    endtask

    // One register setting: extremes first, random ones after.
    task automatic pick_config(input int sel);
        case (sel)
            0: program_regs(7'd64, tla_pkg::END_LENGTH_DEF, tla_pkg::END_BYTES_DEF, 1'b1);
            1: program_regs(7'd2, 4'd1, {$urandom, $urandom}, 1'b1);
            2: program_regs(7'($urandom_range(64, 12)), 4'd8, '1, 1'b1);
            3: program_regs(7'd127, 4'($urandom_range(8, 1)), 64'd0, 1'b1);
            default: program_regs(($urandom_range(3) == 0) ? 7'd64 : 7'($urandom_range(24, 2)),
                                  4'($urandom_range(4, 1)), {$urandom, $urandom}, 1'b1);
        endcase
    endtask

    // Random traffic in one idling mode, under two register settings.
    task automatic test_random_phase(input int in_pct, input int out_pct, input int sel);
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        pick_config(sel);
        random_traffic(28);
        pick_config(sel + 4);
        random_traffic(28);
    endtask

    initial begin
        shadow_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_rx_disabled();
        test_crlf_line();
        test_limit_edges();
        test_long_terminator();
        test_zero_terminator_length();
        test_limit_lowered();
        test_backpressure();
        test_random_phase(0, 0, 0);
        test_random_phase(83, 0, 1);
        test_random_phase(0, 83, 2);
        test_random_phase(28, 28, 3);

        // Let every line drain, then give the verdict.
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYC) @(posedge i_clk);
        if (err_cnt == 0 && line_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== terminated_line_assembler.f =====
design/tla_pkg.sv
design/tla_datapath.sv
design/tla_ctrl.sv
design/terminated_line_assembler.sv
test/terminated_line_assembler_tb.sv
